// File: hdl/indexed_max_priority_queue_core_defines.svh
// Assertion helpers for the priority queue core.
// Both expect clk and arst_n in scope.
`ifndef INDEXED_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define INDEXED_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define IMPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IMPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/impq_pkg.sv
package impq_pkg;

	localparam int IDX_W         = 8;
	localparam int IN_KEY_W      = 32;
	localparam int DEF_CAPACITY  = 256;
	localparam int DEF_KEY_WIDTH = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_DUP   = 2'd3;

	typedef struct packed {
		logic                       cmd;
		logic [IDX_W-1:0]           item_index;
		logic signed [IN_KEY_W-1:0] item_key;
	} in_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic [IDX_W-1:0]           max_index;
		logic signed [IN_KEY_W-1:0] max_key;
	} out_t;

	typedef enum logic [2:0] {
		RD_ROOT   = 3'd0,
		RD_LAST   = 3'd1,
		RD_PARENT = 3'd2,
		RD_CHILD  = 3'd3,
		RD_RIGHT  = 3'd4
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_CARRY = 2'd0,
		WR_RDATA = 2'd1,
		WR_BEST  = 2'd2
	} wr_src_t;

	typedef enum logic [1:0] {
		POS_HOLD   = 2'd0,
		POS_PARENT = 2'd1,
		POS_BEST   = 2'd2
	} pos_upd_t;

	typedef struct packed {
		logic     accept;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_src_t  wr_src;
		pos_upd_t pos_upd;
		logic     take_root;
		logic     take_last;
		logic     take_left;
		logic     take_right;
	} ctl_t;

	typedef struct packed {
		logic ok;
		logic del;
		logic at_root;
		logic no_child;
		logic has_right;
		logic parent_less;
		logic carry_less;
	} sts_t;

endpackage

// File: hdl/impq_ram.sv
module impq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 257
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/impq_dp.sv
module impq_dp #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  impq_pkg::in_t  req,
	input  impq_pkg::ctl_t ctl,
	output impq_pkg::sts_t sts,
	output impq_pkg::out_t rsp
);
	import impq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ENT_W = IDX_W + KEY_WIDTH;
	localparam int IDX_N = 1 << IDX_W;

	// heap entry: {index, key}
	logic [CNT_W-1:0]            count_q;
	logic [IDX_N-1:0]            present_q;
	logic [CNT_W-1:0]            pos_q;
	logic [CNT_W-1:0]            best_pos_q;
	logic [ENT_W-1:0]            carry_q;
	logic [ENT_W-1:0]            best_q;
	logic [1:0]                  status_q;
	logic [IDX_W-1:0]            res_idx_q;
	logic signed [KEY_WIDTH-1:0] res_key_q;

	logic signed [KEY_WIDTH-1:0] in_key;
	logic [1:0]                  code;
	logic [CNT_W:0]              child;
	logic [CNT_W-1:0]            child_a;
	logic [CNT_W-1:0]            raddr;
	logic [ENT_W-1:0]            wdata;
	logic [ENT_W-1:0]            rdata;

	function automatic logic signed [KEY_WIDTH-1:0] key_of(input logic [ENT_W-1:0] e);
		return e[KEY_WIDTH-1:0];
	endfunction

	assign in_key  = KEY_WIDTH'(req.item_key);
	assign child   = {pos_q, 1'b0};
	assign child_a = child[CNT_W-1:0];

	always_comb begin
		if (req.cmd == CMD_INSERT) begin
			if (count_q == CNT_W'(CAPACITY)) begin
				code = ST_FULL;
			end else if (present_q[req.item_index]) begin
				code = ST_DUP;
			end else begin
				code = ST_OK;
			end
		end else begin
			code = (count_q == '0) ? ST_EMPTY : ST_OK;
		end
	end

	always_comb begin
		case (ctl.rd_sel)
			RD_ROOT:   raddr = CNT_W'(1);
			RD_LAST:   raddr = count_q;
			RD_PARENT: raddr = pos_q >> 1;
			RD_CHILD:  raddr = child_a;
			RD_RIGHT:  raddr = child_a | CNT_W'(1);
			default:   raddr = CNT_W'(1);
		endcase
	end

	always_comb begin
		case (ctl.wr_src)
			WR_RDATA: wdata = rdata;
			WR_BEST:  wdata = best_q;
			default:  wdata = carry_q;
		endcase
	end

	impq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY + 1)
	) u_heap (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (pos_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sts.ok          = (code == ST_OK);
	assign sts.del         = (req.cmd == CMD_DELETE);
	assign sts.at_root     = (pos_q == CNT_W'(1));
	assign sts.no_child    = (child > {1'b0, count_q});
	assign sts.has_right   = (child < {1'b0, count_q});
	assign sts.parent_less = (key_of(rdata) < key_of(carry_q));
	assign sts.carry_less  = (key_of(carry_q) < key_of(best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			present_q <= '0;
		end else begin
			if (ctl.accept && code == ST_OK && req.cmd == CMD_INSERT) begin
				count_q                   <= count_q + CNT_W'(1);
				present_q[req.item_index] <= 1'b1;
			end
			if (ctl.take_root) begin
				count_q                            <= count_q - CNT_W'(1);
				present_q[rdata[ENT_W-1 -: IDX_W]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			status_q  <= code;
			res_idx_q <= '0;
			res_key_q <= '0;
			carry_q   <= {req.item_index, in_key};
			pos_q     <= count_q + CNT_W'(1);
		end
		if (ctl.take_root) begin
			res_idx_q <= rdata[ENT_W-1 -: IDX_W];
			res_key_q <= key_of(rdata);
		end
		if (ctl.take_last) begin
			carry_q <= rdata;
			pos_q   <= CNT_W'(1);
		end
		case (ctl.pos_upd)
			POS_PARENT: pos_q <= pos_q >> 1;
			POS_BEST:   pos_q <= best_pos_q;
			default:    ;
		endcase
		if (ctl.take_left) begin
			best_q     <= rdata;
			best_pos_q <= child_a;
		end
		if (ctl.take_right && key_of(best_q) < key_of(rdata)) begin
			best_q     <= rdata;
			best_pos_q <= child_a | CNT_W'(1);
		end
	end

	assign rsp.status    = status_q;
	assign rsp.max_index = res_idx_q;
	assign rsp.max_key   = IN_KEY_W'(res_key_q);

endmodule

// File: hdl/impq_ctrl.sv
module impq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  impq_pkg::sts_t sts,
	output impq_pkg::ctl_t ctl,
	output logic           busy,
	output logic           done
);
	import impq_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_INS_CHK  = 10'b00_0000_0010,
		S_INS_CMP  = 10'b00_0000_0100,
		S_DEL_ROOT = 10'b00_0000_1000,
		S_DEL_LAST = 10'b00_0001_0000,
		S_SNK_CHK  = 10'b00_0010_0000,
		S_SNK_L    = 10'b00_0100_0000,
		S_SNK_R    = 10'b00_1000_0000,
		S_SNK_DEC  = 10'b01_0000_0000,
		S_DONE     = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		ctl     = '0;
		ctl.rd_sel  = RD_ROOT;
		ctl.wr_src  = WR_CARRY;
		ctl.pos_upd = POS_HOLD;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.accept = start;
				if (start) begin
					if (!sts.ok) begin
						state_d = S_DONE;
					end else if (sts.del) begin
						state_d = S_DEL_ROOT;
					end else begin
						state_d = S_INS_CHK;
					end
				end
			end
			S_INS_CHK: begin
				if (sts.at_root) begin
					ctl.wr_en = 1'b1;
					state_d   = S_DONE;
				end else begin
					ctl.rd_sel = RD_PARENT;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				ctl.wr_en = 1'b1;
				if (sts.parent_less) begin
					ctl.wr_src  = WR_RDATA;
					ctl.pos_upd = POS_PARENT;
					state_d     = S_INS_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DEL_ROOT: begin
				ctl.take_root = 1'b1;
				ctl.rd_sel    = RD_LAST;
				state_d       = S_DEL_LAST;
			end
			S_DEL_LAST: begin
				ctl.take_last = 1'b1;
				state_d       = S_SNK_CHK;
			end
			S_SNK_CHK: begin
				if (sts.no_child) begin
					ctl.wr_en = 1'b1;
					state_d   = S_DONE;
				end else begin
					ctl.rd_sel = RD_CHILD;
					state_d    = S_SNK_L;
				end
			end
			S_SNK_L: begin
				ctl.take_left = 1'b1;
				if (sts.has_right) begin
					ctl.rd_sel = RD_RIGHT;
					state_d    = S_SNK_R;
				end else begin
					state_d = S_SNK_DEC;
				end
			end
			S_SNK_R: begin
				ctl.take_right = 1'b1;
				state_d        = S_SNK_DEC;
			end
			S_SNK_DEC: begin
				ctl.wr_en = 1'b1;
				if (sts.carry_less) begin
					ctl.wr_src  = WR_BEST;
					ctl.pos_upd = POS_BEST;
					state_d     = S_SNK_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// File: hdl/indexed_max_priority_queue_core.sv
// Indexed binary max-heap. A transaction is taken on a rising edge with start
// high and busy low; req carries cmd (insert or delete maximum), item_index
// and item_key. Exactly one result per transaction appears on rsp for a
// single cycle with done high; the receiver cannot hold it off.
// Insert: the entry sifts up through a hole, each smaller parent moving down.
// Delete: the root is returned and the last entry sinks from the root. Both
// walks share the single-write, single-registered-read heap memory, which sets
// the pace. A rejected transaction goes straight to done. An insert stops at
// the root or below a parent whose key is not smaller; a delete stops at a
// leaf or where the sinking key is not smaller than its larger child (the left
// one on a tie). An entry moves at most log2(CAPACITY) levels.
// busy stays high until done has been shown; the next transaction may be
// taken in the cycle after done.
// Reset clears the entry count and the presence flags; the heap memory is
// not cleared, since what is read from an unfilled position is never used.
`include "indexed_max_priority_queue_core_defines.svh"

module indexed_max_priority_queue_core #(
	parameter int CAPACITY  = impq_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH = impq_pkg::DEF_KEY_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  impq_pkg::in_t  req,
	output logic           done,
	output impq_pkg::out_t rsp
);
	import impq_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer: walks the sift loops and raises done
	impq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// heap memory, count, presence flags and result registers
	impq_dp #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

	// a result is only ever shown while the block is still busy
	`IMPQ_ASSERT_NOW(a_done_busy, done, busy, "done outside a transaction")
	// an accepted transaction must make the block busy
	`IMPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
	// after the result the block is free again
	`IMPQ_ASSERT_NEXT(a_done_free, done, !busy && !done, "block stuck after result")
	// only a successful delete carries an index and key: a rejected one shows zeros
	`IMPQ_ASSERT_NOW(a_zero_fields, done && rsp.status != ST_OK,
		rsp.max_index == '0 && rsp.max_key == '0, "fields not zero on failure")

endmodule
